### hw/rtl/jitter_entropy_monobit_health_assert.svh
// Assertion macros shared by the monobit health RTL
`ifndef JITTER_ENTROPY_MONOBIT_HEALTH_ASSERT_SVH
`define JITTER_ENTROPY_MONOBIT_HEALTH_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge out of reset
`define JEMH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define JEMH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define JEMH_ASSERT(name, prop, msg)
`define JEMH_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

### hw/rtl/jemh_pkg.sv
`default_nettype none

package jemh_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_BLOCK_BYTES = 2'd0;
  localparam logic [1:0] REG_ONES_LOW    = 2'd1;
  localparam logic [1:0] REG_ONES_HIGH   = 2'd2;
  localparam logic [1:0] REG_FAIL_LIMIT  = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Reset values of the registers
  localparam logic [11:0] BLOCK_BYTES_RST = 12'd2500;
  localparam logic [14:0] ONES_LOW_RST    = 15'd9725;
  localparam logic [14:0] ONES_HIGH_RST   = 15'd10275;
  localparam logic [3:0]  FAIL_LIMIT_RST  = 4'd3;

  localparam int MAX_BLOCK_BYTES_DEF = 4095;
  // Largest length the 12-bit register can hold
  localparam int BLOCK_BYTES_TOP     = 4095;

  localparam logic [2:0] LAST_PHASE = 3'd7;
  localparam logic [3:0] RUN_TOP    = 4'hF;

  typedef struct packed {
    logic [15:0] timer_sample;
  } in_t;

  typedef struct packed {
    logic [7:0]  entropy_byte;
    logic        block_end;
    logic        block_pass;
    logic [14:0] ones_total;
    logic [3:0]  fail_run;
    logic        halted;
  } out_t;

  typedef struct packed {
    logic [11:0] block_bytes;
    logic [14:0] ones_low;
    logic [14:0] ones_high;
    logic [3:0]  fail_limit;
  } cfg_t;

  // Fold stage status towards the block test
  typedef struct packed {
    logic       emit;
    logic [7:0] entropy_byte;
  } fold_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 8; b++) begin
      n = n + 4'(v[b]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/jemh_in_if.sv
`default_nettype none

interface jemh_in_if;
  logic            valid;
  logic            ready;
  jemh_pkg::in_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/jemh_out_if.sv
`default_nettype none

interface jemh_out_if;
  logic            valid;
  logic            ready;
  jemh_pkg::out_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/jemh_fold.sv
`default_nettype none

module jemh_fold (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire logic [15:0]     sample,
  output jemh_pkg::fold_t      fold
);

  logic [7:0] accum_r, accum_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] folded;

  // Fold both sample bytes into the accumulator
  assign folded = accum_r ^ sample[7:0] ^ sample[15:8];

  assign fold.emit         = (phase_r == jemh_pkg::LAST_PHASE);
  assign fold.entropy_byte = folded;

  // Advance the phase; clear the accumulator once a byte leaves
  always_comb begin
    accum_nxt = accum_r;
    phase_nxt = phase_r;
    if (fire) begin
      if (fold.emit) begin
        accum_nxt = 8'd0;
        phase_nxt = 3'd0;
      end else begin
        accum_nxt = folded;
        phase_nxt = phase_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= 8'd0;
      phase_r <= 3'd0;
    end else begin
      accum_r <= accum_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/jemh_test.sv
`default_nettype none

module jemh_test #(
  parameter int MAX_BLOCK_BYTES = jemh_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire jemh_pkg::cfg_t  cfg,
  input  wire logic            step,
  input  wire logic [7:0]      entropy_byte,
  output jemh_pkg::out_t       result,
  output logic                 stopped
);

  // Effective length cap and the position counter width it needs
  localparam int CAP = (MAX_BLOCK_BYTES < jemh_pkg::BLOCK_BYTES_TOP) ?
                       MAX_BLOCK_BYTES : jemh_pkg::BLOCK_BYTES_TOP;
  localparam int POS_W = $clog2(CAP + 1);
  localparam logic [11:0] CAP_V = 12'(CAP);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [14:0]      count_r, count_nxt;
  logic [3:0]       run_r, run_nxt;
  logic             stopped_r, stopped_nxt;

  logic [11:0] limit;
  logic [12:0] pos_inc;
  logic [14:0] count;
  logic        blk_end, pass, halt;
  logic [3:0]  run_inc;

  // Clamp the block length to the supported maximum
  assign limit   = (cfg.block_bytes > CAP_V) ? CAP_V : cfg.block_bytes;
  assign pos_inc = 13'(pos_r) + 13'd1;
  assign count   = count_r + 15'(jemh_pkg::popcount8(entropy_byte));
  assign blk_end = (pos_inc >= {1'b0, limit});
  assign pass    = (count > cfg.ones_low) && (count < cfg.ones_high);
  assign run_inc = (run_r != jemh_pkg::RUN_TOP) ? run_r + 4'd1 : run_r;
  assign halt    = blk_end && !pass && (run_inc >= cfg.fail_limit);

  // Next counts, run and halt flag
  always_comb begin
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    run_nxt     = run_r;
    stopped_nxt = stopped_r;
    if (step) begin
      if (blk_end) begin
        pos_nxt     = '0;
        count_nxt   = 15'd0;
        run_nxt     = pass ? 4'd0 : run_inc;
        stopped_nxt = stopped_r | halt;
      end else begin
        pos_nxt   = pos_inc[POS_W-1:0];
        count_nxt = count;
      end
    end
  end

  // Build the result beat for the byte in hand
  always_comb begin
    result.entropy_byte = entropy_byte;
    result.block_end    = blk_end;
    result.block_pass   = blk_end && pass;
    result.ones_total   = blk_end ? count : 15'd0;
    result.fail_run     = blk_end ? (pass ? 4'd0 : run_inc) : run_r;
    result.halted       = halt;
  end

  assign stopped = stopped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      count_r   <= 15'd0;
      run_r     <= 4'd0;
      stopped_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      count_r   <= count_nxt;
      run_r     <= run_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/jitter_entropy_monobit_health.sv
// Jitter entropy monobit health check.
// in_ch carries one 16-bit timer sample per beat (valid/ready). Every eighth
// sample the block folds the collected bytes into one entropy byte and sends
// it on out_ch together with the monobit verdict when that byte closes a
// test block. Each cfg_we write with cfg_index/cfg_wdata sets one of the four
// registers (block length, lower and upper ones bounds, failure limit);
// write them only while no sample is in flight.
// A sample is captured in the input register; the fold and block test work on
// it there and load its result beat into the result register, which drives
// out_ch. Throughput: one sample per cycle while out_ch does not stall, set by
// the single processing stage between the input and result registers.
// Reset restores the register defaults and clears the fold, the block counts
// and the failure run. When out_ch stalls, the result register holds its
// beat; samples that produce no byte keep flowing, and a sample that would
// produce one waits in the input register, deasserting in_ch.ready.
// After the failure limit is reached every sample is taken and dropped
// until the next reset.
`default_nettype none

module jitter_entropy_monobit_health #(
  parameter int MAX_BLOCK_BYTES = jemh_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  jemh_in_if.sink                               in_ch,
  jemh_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [jemh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [jemh_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

`include "jitter_entropy_monobit_health_assert.svh"

  jemh_pkg::cfg_t  cfg_r;
  logic            s1_v_r;
  logic [15:0]     s1_sample_r;
  logic            out_v_r;
  jemh_pkg::out_t  out_data_r;

  jemh_pkg::fold_t fold;
  jemh_pkg::out_t  result;
  logic            stopped;
  logic            out_free, s1_go, fire, step, emits;

  // Store register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_bytes <= jemh_pkg::BLOCK_BYTES_RST;
      cfg_r.ones_low    <= jemh_pkg::ONES_LOW_RST;
      cfg_r.ones_high   <= jemh_pkg::ONES_HIGH_RST;
      cfg_r.fail_limit  <= jemh_pkg::FAIL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jemh_pkg::REG_BLOCK_BYTES: cfg_r.block_bytes <= cfg_wdata[11:0];
        jemh_pkg::REG_ONES_LOW:    cfg_r.ones_low    <= cfg_wdata[14:0];
        jemh_pkg::REG_ONES_HIGH:   cfg_r.ones_high   <= cfg_wdata[14:0];
        jemh_pkg::REG_FAIL_LIMIT:  cfg_r.fail_limit  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Handshake: move the held sample on unless its byte has nowhere to go
  assign out_free    = !out_v_r || out_ch.ready;
  assign emits       = fold.emit && !stopped;
  assign s1_go       = s1_v_r && (!emits || out_free);
  assign fire        = s1_go && !stopped;
  assign step        = fire && fold.emit;
  assign in_ch.ready = !s1_v_r || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_sample_r <= in_ch.data.timer_sample;
    end
  end

  jemh_fold u_fold (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .sample (s1_sample_r),
    .fold   (fold)
  );

  jemh_test #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_test (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .step         (step),
    .entropy_byte (fold.entropy_byte),
    .result       (result),
    .stopped      (stopped)
  );

  // Result register: load a new beat or drop the taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_data_r;

  `JEMH_ASSERT_NEXT(a_no_beat_after_halt, stopped && !out_v_r, !out_v_r, "beat after halt")
  `JEMH_ASSERT(a_halt_is_fail, !out_v_r || !out_data_r.halted || (out_data_r.block_end && !out_data_r.block_pass), "halt without failed block")
  `JEMH_ASSERT(a_pass_clears_run, !out_v_r || !out_data_r.block_pass || (out_data_r.fail_run == 4'd0), "pass with failure run")
  `JEMH_ASSERT_NEXT(a_stalled_sample_held, s1_v_r && !s1_go, s1_v_r && $stable(s1_sample_r), "held sample lost")

endmodule

`default_nettype wire

### test/jemh_monobit_tracker.sv
module jemh_monobit_tracker
  import jemh_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  jemh_in_if                    in_ch,
  jemh_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copy and health state as the block should hold them
  cfg_t        regs;
  logic [7:0]  fold_acc;
  logic [2:0]  sample_idx;
  logic [11:0] bytes_in_block;
  logic [14:0] ones_in_block;
  logic [3:0]  fail_streak;
  logic        frozen;
  out_t        expected_beats[$];

  // Fold one sample; on every eighth, close out a byte and queue its beat
  task automatic fold_sample(input logic [15:0] sample);
    out_t        beat;
    logic [14:0] ones;
    logic [12:0] pos;
    logic [12:0] len;
    if (frozen) return;
    fold_acc = fold_acc ^ sample[7:0] ^ sample[15:8];
    if (sample_idx != LAST_PHASE) begin
      sample_idx = sample_idx + 3'd1;
      return;
    end
    sample_idx = '0;
    beat = '0;
    beat.entropy_byte = fold_acc;
    fold_acc = '0;
    ones = ones_in_block + 15'($countones(beat.entropy_byte));
    pos = {1'b0, bytes_in_block} + 13'd1;
    len = (regs.block_bytes > MAX_BLOCK_BYTES) ? 13'(MAX_BLOCK_BYTES)
                                                : {1'b0, regs.block_bytes};
    // A block closes once the byte count reaches or passes the length
    if (pos >= len) begin
      beat.block_end  = 1'b1;
      beat.ones_total = ones;
      beat.block_pass = (ones > regs.ones_low) && (ones < regs.ones_high);
      if (beat.block_pass) begin
        fail_streak = '0;
      end else begin
        if (fail_streak != RUN_TOP) fail_streak = fail_streak + 4'd1;
        if (fail_streak >= regs.fail_limit) begin
          beat.halted = 1'b1;
          frozen      = 1'b1;
        end
      end
      ones_in_block  = '0;
      bytes_in_block = '0;
    end else begin
      ones_in_block  = ones;
      bytes_in_block = pos[11:0];
    end
    beat.fail_run = fail_streak;
    expected_beats.push_back(beat);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      regs.block_bytes = BLOCK_BYTES_RST;
      regs.ones_low    = ONES_LOW_RST;
      regs.ones_high   = ONES_HIGH_RST;
      regs.fail_limit  = FAIL_LIMIT_RST;
      fold_acc         = '0;
      sample_idx       = '0;
      bytes_in_block   = '0;
      ones_in_block    = '0;
      fail_streak      = '0;
      frozen           = 1'b0;
      mismatch_count   = 0;
      expected_beats.delete();
    end else begin
      // Compare a result beat with the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat, entropy_byte %0d", out_ch.data.entropy_byte);
          mismatch_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("entropy_byte", want.entropy_byte, out_ch.data.entropy_byte);
          check_field("block_end", want.block_end, out_ch.data.block_end);
          check_field("block_pass", want.block_pass, out_ch.data.block_pass);
          check_field("ones_total", want.ones_total, out_ch.data.ones_total);
          check_field("fail_run", want.fail_run, out_ch.data.fail_run);
          check_field("halted", want.halted, out_ch.data.halted);
        end
      end
      // Register writes take effect at once, halted or not
      if (cfg_we) begin
        case (cfg_index)
          REG_BLOCK_BYTES: regs.block_bytes = cfg_wdata[11:0];
          REG_ONES_LOW:    regs.ones_low    = cfg_wdata[14:0];
          REG_ONES_HIGH:   regs.ones_high   = cfg_wdata[14:0];
          REG_FAIL_LIMIT:  regs.fail_limit  = cfg_wdata[3:0];
        endcase
      end
      if (in_ch.valid && in_ch.ready) fold_sample(in_ch.data.timer_sample);
    end
    pending_count = expected_beats.size();
  end

endmodule

### test/jitter_entropy_monobit_health_tb.sv
module jitter_entropy_monobit_health_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jemh_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  // Opening samples: extremes, single-bit and other fixed patterns of the timer field
  localparam logic [15:0] OPENING [16] = '{
    16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h5AA5, 16'hA55A, 16'h8000, 16'h0001,
    16'h7FFF, 16'hFFFE, 16'h0F0F, 16'hF0F0, 16'h0100, 16'h0080, 16'h3C3C, 16'hC3C3
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatch_count;
  int                    pending_count;
  bit                    steady;

  jemh_in_if  in_ch ();
  jemh_out_if out_ch ();

  jitter_entropy_monobit_health u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  jemh_monobit_tracker u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random, except during the steady stretch
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 31);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("jitter_entropy_monobit_health: mismatch");
    $finish;
  end

  // Offer one sample after a random gap; return at the falling edge after the beat
  task automatic push_sample(input logic [15:0] s);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.timer_sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Send eight samples; when shaped, the last one steers the fold to target
  task automatic send_byte(input logic [7:0] target, input bit shaped);
    logic [7:0]  acc;
    logic [15:0] s;
    acc = '0;
    for (int i = 0; i < 7; i++) begin
      s = 16'($urandom);
      acc = acc ^ s[7:0] ^ s[15:8];
      push_sample(s);
    end
    s[15:8] = 8'($urandom);
    s[7:0]  = shaped ? (s[15:8] ^ acc ^ target) : 8'($urandom);
    push_sample(s);
  endtask

  // Drop valid and wait until every expected beat has arrived
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_test(input logic [11:0] blk, input logic [14:0] lo,
                              input logic [14:0] hi, input logic [3:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BLOCK_BYTES;
    cfg_wdata <= CFG_DATA_W'(blk);
    @(negedge clk);
    cfg_index <= REG_ONES_LOW;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= REG_ONES_HIGH;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_index <= REG_FAIL_LIMIT;
    cfg_wdata <= CFG_DATA_W'(lim);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          n;
    int          eff;
    int          d;
    int          nbytes;
    logic [14:0] lo;
    logic [14:0] hi;
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = REG_BLOCK_BYTES;
    cfg_wdata               = '0;
    in_ch.valid             = 1'b0;
    in_ch.data.timer_sample = '0;
    steady                  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Two bytes under the reset settings, far from a block end
    for (int i = 0; i < 16; i++) push_sample(OPENING[i]);
    settle();

    // Lower the length mid-block: the next byte closes it; zero bytes fail
    program_test(12'd1, 15'd0, 15'd32767, 4'd15);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b1);
    settle();

    // Zero length closes on every byte; bounds are exclusive
    program_test(12'd0, 15'd3, 15'd5, 4'd15);
    send_byte(8'h0F, 1'b1);
    send_byte(8'hF0, 1'b1);
    send_byte(8'h07, 1'b1);
    send_byte(8'h1F, 1'b1);
    send_byte(8'h33, 1'b1);
    settle();

    // Empty windows grow the failure run; passing all-ones blocks then clear it
    program_test(12'd2, 15'd10, 15'd11, 4'd15);
    for (int i = 0; i < 8; i++) send_byte(8'h00, 1'b0);
    settle();
    program_test(12'd1, 15'd32767, 15'd0, 4'd15);
    for (int i = 0; i < 2; i++) send_byte(8'h00, 1'b0);
    settle();
    program_test(12'd3, 15'd0, 15'd32767, 4'd15);
    for (int i = 0; i < 6; i++) send_byte(8'hFF, 1'b1);
    settle();

    // Stop one failure short of the limit, then clear the run
    program_test(12'd1, 15'd0, 15'd1, 4'd4);
    for (int i = 0; i < 3; i++) send_byte(8'hFF, 1'b1);
    settle();
    program_test(12'd1, 15'd0, 15'd32767, 4'd15);
    send_byte(8'hFF, 1'b1);
    settle();

    // One block of all-ones bytes in a narrow window, with no idling
    steady = 1'b1;
    program_test(12'd24, 15'd191, 15'd193, 4'd15);
    for (int i = 0; i < 24; i++) send_byte(8'hFF, 1'b1);
    settle();
    steady = 1'b0;

    // Random phases: short blocks, windows around the expected ones count
    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(0, 9))
        0:       n = 0;
        1, 2:    n = 1;
        3, 4:    n = 2;
        5:       n = 3;
        6:       n = 5;
        7:       n = 8;
        8:       n = 16;
        default: n = $urandom_range(1, 40);
      endcase
      eff = (n == 0) ? 1 : n;
      d   = 1 + $rtoi(1.5 * $sqrt(2.0 * eff));
      if ($urandom_range(0, 3) == 0) begin
        lo = 15'd0;
        hi = 15'd32767;
      end else begin
        lo = (4 * eff > d) ? 15'(4 * eff - d) : 15'd0;
        hi = 15'(4 * eff + d);
      end
      program_test(12'(n), lo, hi, 4'd15);
      nbytes = $urandom_range(6, 12);
      for (int i = 0; i < nbytes; i++) begin
        case ($urandom_range(0, 9))
          0:       send_byte(8'h00, 1'b1);
          1:       send_byte(8'hFF, 1'b1);
          default: send_byte(8'h00, 1'b0);
        endcase
      end
      settle();
    end

    // Zero failure limit: the first failed block halts, later samples are dropped
    program_test(12'd1, 15'd32767, 15'd32767, 4'd0);
    send_byte(8'h00, 1'b0);
    for (int i = 0; i < 16; i++) push_sample(16'($urandom));
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("jitter_entropy_monobit_health: match");
    end else begin
      $display("jitter_entropy_monobit_health: mismatch");
    end
    $finish;
  end

endmodule
